### hw/rtl/node_address_table_core_assert.svh
// assertion macros used by the node address table checker
`ifndef NODE_ADDRESS_TABLE_CORE_ASSERT_SVH
`define NODE_ADDRESS_TABLE_CORE_ASSERT_SVH

// concurrent assertion on a given clock and active-low reset
`define NAT_ASSERT(name, clk_sig, rstn_sig, prop, msg) \
	name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
		else $error(msg);

// concurrent assertion on the block clock and reset
`define NAT_CHECK(name, prop, msg) `NAT_ASSERT(name, clk, arst_n, prop, msg)

`endif

### hw/rtl/nat_pkg.sv
// shared constants, codes and control types of the node address table
`default_nettype none

package nat_pkg;

	// table geometry
	localparam int TABLE_SIZE = 32;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

	// item field widths
	localparam int CMD_W      = 2;
	localparam int ADDR_W     = 48;
	localparam int POS_W      = 5;
	localparam int STATUS_W   = 3;
	localparam int COUNT_W    = 6;

	// width that holds both a position and a fill count
	localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_ADD     = 2'd0,
		CMD_DISABLE = 2'd1,
		CMD_ENABLE  = 2'd2
	} cmd_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_APPENDED  = 3'd0,
		ST_SWAPPED   = 3'd1,
		ST_REPLACED  = 3'd2,
		ST_FLAG      = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_BAD_POS   = 3'd5
	} status_t;

	// source of the reported slot
	typedef enum logic [1:0] {
		IDX_ZERO = 2'd0,
		IDX_POS  = 2'd1,
		IDX_SLOT = 2'd2
	} idx_sel_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE      = 3'd0,
		S_DECIDE    = 3'd1,
		S_SEARCH    = 3'd2,
		S_RD_POS    = 3'd3,
		S_SWAP_SLOT = 3'd4,
		S_SWAP_POS  = 3'd5,
		S_RESULT    = 3'd6
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic     load;
		logic     search;
		logic     rd_pos;
		logic     wr_en;
		logic     wr_swap;
		logic     en_write;
		logic     en_val;
		logic     en_at_slot;
		logic     cnt_inc;
		logic     res_load;
		status_t  res_status;
		idx_sel_t res_idx_sel;
		logic     out_load;
	} ctl_t;

	// status from datapath to controller
	typedef struct packed {
		logic cmd_add;
		logic cmd_flag;
		logic cmd_en;
		logic pos_eq_cnt;
		logic pos_bad;
		logic full;
		logic search_done;
		logic hit;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

### hw/rtl/nat_in_if.sv
// request channel of the node address table
`default_nettype none

interface nat_in_if import nat_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [ADDR_W-1:0] node_addr;
	logic [POS_W-1:0]  position;

	modport source (output valid, cmd, node_addr, position, input ready);
	modport sink   (input valid, cmd, node_addr, position, output ready);

endinterface

`default_nettype wire

### hw/rtl/nat_out_if.sv
// response channel of the node address table
`default_nettype none

interface nat_out_if import nat_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    match_index;
	logic [COUNT_W-1:0]  entry_count;

	modport source (output valid, status, match_index, entry_count, input ready);
	modport sink   (input valid, status, match_index, entry_count, output ready);

endinterface

`default_nettype wire

### hw/rtl/nat_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none

module nat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/nat_datapath.sv
// datapath: item registers, address ram, scan pipeline, flags, count and result register
`default_nettype none

module nat_datapath import nat_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CMD_W-1:0]    req_cmd,
	input  logic [ADDR_W-1:0]   req_node_addr,
	input  logic [POS_W-1:0]    req_position,
	input  ctl_t                ctl,
	output sts_t                sts,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [STATUS_W-1:0] rsp_status,
	output logic [POS_W-1:0]    rsp_match_index,
	output logic [COUNT_W-1:0]  rsp_entry_count
);

	// item registers
	logic [CMD_W-1:0]    cmd_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [POS_W-1:0]    pos_q;

	// table state
	logic [CNT_W-1:0]    cnt_q;
	logic [TABLE_SIZE-1:0] en_q;

	// scan state
	logic [CNT_W-1:0]    scan_q;
	logic                cmp_vld_s1;
	logic [IDX_W-1:0]    cmp_idx_s1;
	logic                hit_q;
	logic [IDX_W-1:0]    slot_q;

	// pending and delivered result
	logic [STATUS_W-1:0] res_status_q;
	logic [IDX_W-1:0]    res_idx_q;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [POS_W-1:0]    rsp_idx_q;
	logic [COUNT_W-1:0]  rsp_cnt_q;

	// ram ports
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [ADDR_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [IDX_W-1:0]    ram_raddr;
	logic [ADDR_W-1:0]   ram_rdata;

	logic                issue;
	logic                cmp_hit;
	logic [IDX_W-1:0]    pos_idx;
	logic [IDX_W-1:0]    en_idx;
	logic [IDX_W-1:0]    res_idx_d;
	logic [CMP_W-1:0]    pos_cmp;
	logic [CMP_W-1:0]    cnt_cmp;

	assign pos_idx = IDX_W'(pos_q);
	assign pos_cmp = CMP_W'(pos_q);
	assign cnt_cmp = CMP_W'(cnt_q);

	// scan issues one stored address per cycle until count or first hit
	assign issue   = ctl.search && (scan_q < cnt_q) && !hit_q;
	assign cmp_hit = cmp_vld_s1 && !hit_q && (ram_rdata == addr_q);

	// address store
	assign ram_we    = ctl.wr_en;
	assign ram_waddr = ctl.wr_swap ? slot_q : pos_idx;
	assign ram_wdata = ctl.wr_swap ? ram_rdata : addr_q;
	assign ram_re    = ctl.rd_pos || issue;
	assign ram_raddr = ctl.rd_pos ? pos_idx : IDX_W'(scan_q);

	nat_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(TABLE_SIZE)
	) u_addr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign en_idx = ctl.en_at_slot ? slot_q : pos_idx;

	// reported slot select
	always_comb begin
		case (ctl.res_idx_sel)
			IDX_POS:  res_idx_d = pos_idx;
			IDX_SLOT: res_idx_d = slot_q;
			default:  res_idx_d = '0;
		endcase
	end

	// control state: count, flags, scan progress, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			en_q        <= '0;
			scan_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				scan_q     <= '0;
				cmp_vld_s1 <= 1'b0;
				hit_q      <= 1'b0;
			end else if (ctl.search) begin
				cmp_vld_s1 <= issue;
				if (issue) begin
					scan_q <= scan_q + CNT_W'(1);
				end
				if (cmp_hit) begin
					hit_q <= 1'b1;
				end
			end else begin
				cmp_vld_s1 <= 1'b0;
			end
			if (ctl.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (ctl.en_write) begin
				en_q[en_idx] <= ctl.en_val;
			end
			if (ctl.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= req_cmd;
			addr_q <= req_node_addr;
			pos_q  <= req_position;
		end
		if (ctl.search) begin
			cmp_idx_s1 <= IDX_W'(scan_q);
		end
		if (cmp_hit && ctl.search) begin
			slot_q <= cmp_idx_s1;
		end
		if (ctl.res_load) begin
			res_status_q <= ctl.res_status;
			res_idx_q    <= res_idx_d;
		end
		if (ctl.out_load) begin
			rsp_status_q <= res_status_q;
			rsp_idx_q    <= POS_W'(res_idx_q);
			rsp_cnt_q    <= COUNT_W'(cnt_q);
		end
	end

	// status toward the controller
	always_comb begin
		sts.cmd_add     = (cmd_q == CMD_ADD);
		sts.cmd_flag    = (cmd_q inside {CMD_DISABLE, CMD_ENABLE});
		sts.cmd_en      = (cmd_q == CMD_ENABLE);
		sts.pos_eq_cnt  = (pos_cmp == cnt_cmp);
		sts.pos_bad     = (pos_cmp > cnt_cmp) || (pos_cmp >= CMP_W'(TABLE_SIZE));
		sts.full        = (cnt_q == CNT_W'(TABLE_SIZE));
		sts.search_done = hit_q || (!cmp_vld_s1 && (scan_q >= cnt_q));
		sts.hit         = hit_q;
		sts.out_free    = !rsp_valid_q || rsp_ready;
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp_status      = rsp_status_q;
	assign rsp_match_index = rsp_idx_q;
	assign rsp_entry_count = rsp_cnt_q;

endmodule

`default_nettype wire

### hw/rtl/nat_ctrl.sv
// controller state machine sequencing decide, scan, swap and result
`default_nettype none

module nat_ctrl import nat_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output ctl_t ctl,
	input  sts_t sts
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d             = state_q;
		in_ready            = 1'b0;
		ctl                 = '0;
		ctl.res_status      = ST_NOT_FOUND;
		ctl.res_idx_sel     = IDX_ZERO;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.cmd_add) begin
					if (sts.pos_eq_cnt) begin
						ctl.res_load = 1'b1;
						if (sts.full) begin
							ctl.res_status = ST_BAD_POS;
						end else begin
							// append at the end and enable
							ctl.wr_en       = 1'b1;
							ctl.en_write    = 1'b1;
							ctl.en_val      = 1'b1;
							ctl.cnt_inc     = 1'b1;
							ctl.res_status  = ST_APPENDED;
							ctl.res_idx_sel = IDX_POS;
						end
						state_d = S_RESULT;
					end else if (sts.pos_bad) begin
						ctl.res_load   = 1'b1;
						ctl.res_status = ST_BAD_POS;
						state_d        = S_RESULT;
					end else begin
						state_d = S_SEARCH;
					end
				end else if (sts.cmd_flag) begin
					state_d = S_SEARCH;
				end else begin
					ctl.res_load = 1'b1;
					state_d      = S_RESULT;
				end
			end
			S_SEARCH: begin
				ctl.search = 1'b1;
				if (sts.search_done) begin
					if (sts.cmd_add) begin
						if (sts.hit) begin
							state_d = S_RD_POS;
						end else begin
							// overwrite the named slot and enable it
							ctl.wr_en       = 1'b1;
							ctl.en_write    = 1'b1;
							ctl.en_val      = 1'b1;
							ctl.res_load    = 1'b1;
							ctl.res_status  = ST_REPLACED;
							ctl.res_idx_sel = IDX_POS;
							state_d         = S_RESULT;
						end
					end else begin
						ctl.res_load = 1'b1;
						if (sts.hit) begin
							ctl.en_write    = 1'b1;
							ctl.en_at_slot  = 1'b1;
							ctl.en_val      = sts.cmd_en;
							ctl.res_status  = ST_FLAG;
							ctl.res_idx_sel = IDX_SLOT;
						end
						state_d = S_RESULT;
					end
				end
			end
			S_RD_POS: begin
				ctl.rd_pos = 1'b1;
				state_d    = S_SWAP_SLOT;
			end
			S_SWAP_SLOT: begin
				// displaced address moves to the found slot
				ctl.wr_en   = 1'b1;
				ctl.wr_swap = 1'b1;
				state_d     = S_SWAP_POS;
			end
			S_SWAP_POS: begin
				ctl.wr_en       = 1'b1;
				ctl.res_load    = 1'b1;
				ctl.res_status  = ST_SWAPPED;
				ctl.res_idx_sel = IDX_SLOT;
				state_d         = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/node_address_table_core.sv
// top level of the node address table
//
//  port  direction  payload                                   role
//  req   sink       cmd, node_addr, position                  add / disable / enable item
//  rsp   source     status, match_index, entry_count          one result item per request
//
// one item at a time; a lookup scans the filled slots up to the first hit or the fill count,
// a swap then reads the named slot and writes both slots, and an append, a rejected add or
// an unused command goes from decide straight to result; the scan reads one stored
// address per cycle through the single read port of the address ram
// the next item can be taken in the cycle after its result is loaded into the output register
// reset clears the fill count and all enabled bits; addresses are not cleared
// a new item is taken while the previous result still waits in the output register;
// its own result then waits in the controller until the register frees

`default_nettype none

module node_address_table_core import nat_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	nat_in_if.sink    req,
	nat_out_if.source rsp
);

	ctl_t ctl;
	sts_t sts;

	// sequencer
	nat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.ctl      (ctl),
		.sts      (sts)
	);

	// table and result datapath
	nat_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_cmd         (req.cmd),
		.req_node_addr   (req.node_addr),
		.req_position    (req.position),
		.ctl             (ctl),
		.sts             (sts),
		.rsp_valid       (rsp.valid),
		.rsp_ready       (rsp.ready),
		.rsp_status      (rsp.status),
		.rsp_match_index (rsp.match_index),
		.rsp_entry_count (rsp.entry_count)
	);

endmodule

`default_nettype wire

### hw/rtl/nat_checker.sv
// port-level checker for the node address table, bound to the top level
`default_nettype none

`include "node_address_table_core_assert.svh"

module nat_checker import nat_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] rsp_status,
	input logic [POS_W-1:0]    rsp_match_index,
	input logic [COUNT_W-1:0]  rsp_entry_count
);

	// a pending result stays offered
	`NAT_CHECK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result item dropped")

	// one item in work at a time
	`NAT_CHECK(a_one_in_work, req_valid && req_ready |=> !req_ready, "second item taken")

	// an append lands on the last filled slot
	`NAT_CHECK(a_append_slot, rsp_valid && (rsp_status == ST_APPENDED) |-> (COUNT_W'(rsp_match_index) + COUNT_W'(1)) == rsp_entry_count, "append slot mismatch")

	// misses and rejected adds report slot zero
	`NAT_CHECK(a_zero_slot, rsp_valid && (rsp_status == ST_NOT_FOUND || rsp_status == ST_BAD_POS) |-> rsp_match_index == '0, "nonzero slot on miss")

endmodule

bind node_address_table_core nat_checker u_nat_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_match_index (rsp.match_index),
	.rsp_entry_count (rsp.entry_count)
);

`default_nettype wire

### tb/nat_table_scoreboard.sv
// scoreboard for the node address table: tracks the table contents and checks every reply item

module nat_table_scoreboard import nat_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	nat_in_if    req,
	nat_out_if   rsp,
	output int   errors,
	output int   pending,
	output int   replies_seen,
	output logic [7:0] codes_seen,
	output int   peak_fill
);

	// one reply item as the table should produce it
	typedef struct packed {
		status_t           status;
		logic [POS_W-1:0]  match_index;
		logic [COUNT_W-1:0] entry_count;
	} table_reply_t;

	// shadow copy of the table
	logic [ADDR_W-1:0] slot_addr [TABLE_SIZE];
	logic              slot_on   [TABLE_SIZE];
	int                fill;
	table_reply_t      reply_q   [$];

	// lowest filled slot holding the address, or the fill count on a miss
	function automatic int lowest_slot_of(input logic [ADDR_W-1:0] a);
		for (int i = 0; i < fill && i < TABLE_SIZE; i++) begin
			if (slot_addr[i] == a)
				return i;
		end
		return fill;
	endfunction

	// update the shadow table for one request item and queue its reply
	task automatic apply_table_op(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
			input logic [POS_W-1:0] p);
		table_reply_t want;
		int           pos_i;
		int           hit;
		pos_i = p;
		want.status      = ST_NOT_FOUND;
		want.match_index = '0;
		case (c)
			CMD_ADD: begin
				if (pos_i == fill) begin
					if (fill < TABLE_SIZE) begin
						slot_addr[pos_i] = a;
						slot_on[pos_i]   = 1'b1;
						fill++;
						want.status      = ST_APPENDED;
						want.match_index = p;
					end else begin
						want.status = ST_BAD_POS;
					end
				end else if (pos_i > fill || pos_i >= TABLE_SIZE) begin
					want.status = ST_BAD_POS;
				end else begin
					hit = lowest_slot_of(a);
					if (hit >= fill) begin
						// new address overwrites the slot and enables it
						slot_addr[pos_i] = a;
						slot_on[pos_i]   = 1'b1;
						want.status      = ST_REPLACED;
						want.match_index = p;
					end else begin
						// addresses trade slots, enabled bits stay put
						slot_addr[hit]   = slot_addr[pos_i];
						slot_addr[pos_i] = a;
						want.status      = ST_SWAPPED;
						want.match_index = hit[POS_W-1:0];
					end
				end
			end
			CMD_DISABLE, CMD_ENABLE: begin
				hit = lowest_slot_of(a);
				if (hit < fill) begin
					slot_on[hit]     = (c == CMD_ENABLE);
					want.status      = ST_FLAG;
					want.match_index = hit[POS_W-1:0];
				end
			end
			default: ;
		endcase
		want.entry_count = fill[COUNT_W-1:0];
		if (fill > peak_fill)
			peak_fill = fill;
		reply_q.push_back(want);
	endtask

	// compare one reply item with the oldest queued one
	task automatic check_reply();
		table_reply_t want;
		replies_seen++;
		codes_seen[rsp.status] = 1'b1;
		if (reply_q.size() == 0) begin
			$error("reply item with no request waiting: status %0d index %0d count %0d",
				rsp.status, rsp.match_index, rsp.entry_count);
			errors++;
			return;
		end
		want = reply_q.pop_front();
		if (rsp.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, rsp.status);
			errors++;
		end
		if (rsp.match_index !== want.match_index) begin
			$error("match_index: expected %0d, got %0d", want.match_index, rsp.match_index);
			errors++;
		end
		if (rsp.entry_count !== want.entry_count) begin
			$error("entry_count: expected %0d, got %0d", want.entry_count, rsp.entry_count);
			errors++;
		end
	endtask

	// watch both channels at every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			for (int i = 0; i < TABLE_SIZE; i++) begin
				slot_addr[i] = '0;
				slot_on[i]   = 1'b0;
			end
			reply_q.delete();
			errors       = 0;
			replies_seen = 0;
			codes_seen   = '0;
			peak_fill    = 0;
			pending     <= 0;
		end else begin
			if (rsp.valid && rsp.ready)
				check_reply();
			if (req.valid && req.ready)
				apply_table_op(req.cmd, req.node_addr, req.position);
			pending <= reply_q.size();
		end
	end

endmodule

### tb/tb_node_address_table_core.sv
// testbench top for the node address table: clock, reset, request stimulus and verdict

module tb_node_address_table_core;
	import nat_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1830;
	localparam int POOL_SIZE    = 48;
	localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = '1;
	localparam logic [ADDR_W-1:0] ADDR_A = 48'hA5A5_5A5A_0F0F;
	localparam logic [ADDR_W-1:0] ADDR_B = 48'h0123_4567_89AB;

	logic clk = 1'b0;
	logic arst_n;

	nat_in_if  req_ch ();
	nat_out_if rsp_ch ();

	int errors;
	int pending;
	int replies_seen;
	logic [7:0] codes_seen;
	int peak_fill;

	int fill_level;
	int burst_left;
	int n_sent;
	int stall_mode;
	int stall_span;
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

	node_address_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	nat_table_scoreboard scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.errors       (errors),
		.pending      (pending),
		.replies_seen (replies_seen),
		.codes_seen   (codes_seen),
		.peak_fill    (peak_fill)
	);

	// clock
	always #10 clk = ~clk;

	// hard limit on the run
	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	// reply stalls: stretches of always ready, random ready and mostly stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_mode   <= 0;
			stall_span   <= 0;
		end else begin
			if (stall_span == 0) begin
				stall_mode <= $urandom_range(0, 2);
				stall_span <= $urandom_range(10, 150);
			end else begin
				stall_span <= stall_span - 1;
			end
			case (stall_mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= 1'($urandom_range(0, 1));
				default: rsp_ch.ready <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	// offer one request item, with a random gap at the start of each burst
	task automatic send_item(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
			input logic [POS_W-1:0] p);
		int gap;
		int roll;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			roll = $urandom_range(0, 99);
			if (roll < 25)
				gap = 0;
			else if (roll < 85)
				gap = $urandom_range(1, 6);
			else
				gap = $urandom_range(7, 45);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= c;
		req_ch.node_addr <= a;
		req_ch.position  <= p;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		burst_left--;
		n_sent++;
		// an add at the fill count grows the table
		if (c == CMD_ADD && p == fill_level && fill_level < TABLE_SIZE)
			fill_level++;
	endtask

	// stimulus and verdict
	initial begin
		logic [CMD_W-1:0]  op;
		logic [ADDR_W-1:0] addr;
		logic [POS_W-1:0]  pos;
		logic [63:0]       wide;
		int                roll;

		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.cmd       = CMD_ADD;
		req_ch.node_addr = '0;
		req_ch.position  = '0;
		fill_level       = 0;
		burst_left       = 0;
		n_sent           = 0;

		// address pool: extremes and two fixed patterns first, the rest random
		for (int i = 0; i < POOL_SIZE; i++) begin
			wide = {$urandom, $urandom};
			addr_pool[i] = wide[ADDR_W-1:0];
		end
		addr_pool[0] = '0;
		addr_pool[1] = ADDR_ALL_ONES;
		addr_pool[2] = ADDR_A;
		addr_pool[3] = ADDR_B;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lookups and unused command on an empty table
		send_item(CMD_ENABLE, '0, 5'd0);
		send_item(CMD_DISABLE, ADDR_ALL_ONES, 5'd31);
		send_item(CMD_UNUSED, ADDR_A, 5'd0);
		// positions beyond the count
		send_item(CMD_ADD, ADDR_A, 5'd31);
		send_item(CMD_ADD, ADDR_A, 5'd1);
		// appends
		send_item(CMD_ADD, ADDR_ALL_ONES, 5'd0);
		send_item(CMD_ADD, '0, 5'd1);
		send_item(CMD_ADD, ADDR_A, 5'd2);
		// flag changes on stored addresses
		send_item(CMD_DISABLE, ADDR_ALL_ONES, 5'd7);
		send_item(CMD_ENABLE, '0, 5'd0);
		// swap with another slot, then swap with itself
		send_item(CMD_ADD, ADDR_A, 5'd0);
		send_item(CMD_ADD, '0, 5'd1);
		// replace, then append the displaced address again
		send_item(CMD_ADD, ADDR_B, 5'd1);
		send_item(CMD_ADD, '0, 5'd3);
		send_item(CMD_DISABLE, ADDR_B, 5'd0);
		send_item(CMD_ENABLE, 48'h0000_0000_0123, 5'd0);
		send_item(CMD_UNUSED, ADDR_B, 5'd31);
		send_item(CMD_ADD, ADDR_B, 5'd5);
		// duplicate entry: the lowest slot wins on lookup and swap
		send_item(CMD_ADD, ADDR_A, 5'd4);
		send_item(CMD_DISABLE, ADDR_A, 5'd0);
		send_item(CMD_ADD, ADDR_A, 5'd2);

		// random part: mostly pool addresses so lookups hit, slow table growth
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			roll = $urandom_range(0, 99);
			wide = {$urandom, $urandom};
			if ($urandom_range(0, 4) == 0)
				addr = wide[ADDR_W-1:0];
			else
				addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			pos = POS_W'($urandom_range(0, TABLE_SIZE - 1));
			if (roll < 50) begin
				op = CMD_ADD;
				roll = $urandom_range(0, 99);
				if (roll < 6 && fill_level < TABLE_SIZE)
					pos = fill_level[POS_W-1:0];
				else if (roll >= 16 && fill_level > 0)
					pos = POS_W'($urandom_range(0, fill_level - 1));
				// fresh addresses sometimes join the pool so they come back later
				if (addr == wide[ADDR_W-1:0] && $urandom_range(0, 1) == 1)
					addr_pool[$urandom_range(4, POOL_SIZE - 1)] = addr;
			end else if (roll < 72) begin
				op = CMD_DISABLE;
			end else if (roll < 95) begin
				op = CMD_ENABLE;
			end else begin
				op = CMD_UNUSED;
			end
			send_item(op, addr, pos);
		end
		req_ch.valid <= 1'b0;

		// drain the outstanding replies, then watch for stray ones
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (60) @(posedge clk);

		$display("%0d request items sent, %0d reply items checked, status codes seen %b",
			n_sent, replies_seen, codes_seen[5:0]);
		$display("table filled to %0d of %0d slots", peak_fill, TABLE_SIZE);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
